// File: src/dop_pkg.sv
`default_nettype none

package dop_pkg;

    // Parser phase: where the next options byte falls in the code/length/value walk
    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    // Stop reasons carried in the result
    localparam logic [1:0] STOP_END_CODE  = 2'd0;
    localparam logic [1:0] STOP_LIMIT     = 2'd1;
    localparam logic [1:0] STOP_PKT_END   = 2'd2;
    localparam logic [1:0] STOP_TRUNCATED = 2'd3;

    // Option codes of interest
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_SUBNET   = 8'd1;
    localparam logic [7:0] OPT_GATEWAY  = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'hFF;

    // Found-mask bit positions
    localparam int FOUND_SUBNET = 0;
    localparam int FOUND_ROUTER = 1;
    localparam int FOUND_DNS    = 2;
    localparam int FOUND_LEASE  = 3;
    localparam int FOUND_TYPE   = 4;

    localparam logic [9:0] LIMIT_RESET = 10'd308;
    localparam logic [9:0] POS_MAX     = 10'd1023;
    localparam logic [2:0] VALUE_BYTES = 3'd4;

    localparam int RESULT_W = 144;

    // Summary result, packed first field in the highest bits
    typedef struct packed {
        logic       pad;
        logic [1:0] stop_reason;
        logic [4:0] found_mask;
        logic [7:0] message_type;
        logic [31:0] lease_seconds;
        logic [31:0] dns_server;
        logic [31:0] router;
        logic [31:0] net_mask;
    } result_t;

endpackage

`default_nettype wire

// File: src/dhcp_option_parser_unit.sv
`default_nettype none

// DHCP options-area parser.
// Input channel (s_axis_*): one options byte per transaction in wire order; tuser
// marks the first byte of a new options area (clears all parse state), tlast the
// final byte available for the packet. Output channel (m_axis_*): one summary
// transaction per options area, carrying the captured subnet mask, router, DNS
// server, lease time, message type, the found mask and the stop reason.
// Parsing stops at the end code, when an option code would start at or beyond
// the byte limit, or at tlast; bytes after that are dropped until the next first.
// Configuration: cfg_we writes cfg_wdata into the byte limit (reset 308); write
// only while no area is being parsed.
// Throughput: one byte per cycle while s_axis_tready is high. Parse state
// updates in the accepting cycle, which also registers a completed summary.
// A two-entry output stage (result register plus skid register) decouples the
// sides: s_axis_tready falls only when both entries hold results, so a stalled
// receiver stops the input after a second pending summary.
// Reset: all parse state clears, the limit returns to 308, the output empties.
module dhcp_option_parser_unit
    import dop_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [9:0]          cfg_wdata,      // option_limit
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  wire logic                s_axis_tuser,   // [0] first
    input  wire logic                s_axis_tlast,   // last
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [31:0] net_mask, [63:32] router, [95:64] dns_server,
    // [127:96] lease_seconds, [135:128] message_type, [140:136] found_mask,
    // [142:141] stop_reason, [143] zero
    output logic [RESULT_W-1:0]      m_axis_tdata
);

    // Configuration
    logic [9:0]  limit_reg;

    // Parse state
    phase_t      phase_reg,      phase_next;
    logic [7:0]  code_reg,       code_next;
    logic [7:0]  left_reg,       left_next;
    logic [2:0]  vidx_reg,       vidx_next;
    logic [31:0] vshift_reg,     vshift_next;
    logic [9:0]  position_reg,   position_next;
    logic [31:0] subnet_reg,     subnet_next;
    logic [31:0] router_reg,     router_next;
    logic [31:0] dns_reg,        dns_next;
    logic [31:0] lease_reg,      lease_next;
    logic [7:0]  type_reg,       type_next;
    logic [4:0]  seen_reg,       seen_next;

    // Output stage
    logic        out_valid_reg;
    logic        skid_valid_reg;
    result_t     out_reg;
    result_t     skid_reg;

    logic        s_accept;
    logic        m_pop;
    logic        emit;
    logic [1:0]  reason;
    result_t     result;

    // Effective state after the first-byte clear
    phase_t      cur_phase;
    logic [9:0]  cur_pos;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_pop         = out_valid_reg && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign cur_phase = s_axis_tuser ? PH_CODE : phase_reg;
    assign cur_pos   = s_axis_tuser ? 10'd0 : position_reg;

    // Next-state logic for one accepted byte. Closing an option aligns the captured
    // bytes to the top of the word and stores them in the slot of the option code.
    always_comb
    begin : next_state
        logic [31:0] word;
        logic [7:0]  lead;
        logic        finish;
        logic [2:0]  n;

        word   = '0;
        lead   = '0;
        finish = 1'b0;
        n      = '0;
        emit   = 1'b0;
        reason = STOP_END_CODE;

        if (s_axis_tuser)
        begin
            phase_next    = PH_CODE;
            code_next     = '0;
            left_next     = '0;
            vidx_next     = '0;
            vshift_next   = '0;
            position_next = '0;
            subnet_next   = '0;
            router_next   = '0;
            dns_next      = '0;
            lease_next    = '0;
            type_next     = '0;
            seen_next     = '0;
        end
        else
        begin
            phase_next    = phase_reg;
            code_next     = code_reg;
            left_next     = left_reg;
            vidx_next     = vidx_reg;
            vshift_next   = vshift_reg;
            position_next = position_reg;
            subnet_next   = subnet_reg;
            router_next   = router_reg;
            dns_next      = dns_reg;
            lease_next    = lease_reg;
            type_next     = type_reg;
            seen_next     = seen_reg;
        end

        unique case (cur_phase)
            PH_CODE:
            begin
                if (cur_pos >= limit_reg)
                begin
                    emit   = 1'b1;
                    reason = STOP_LIMIT;
                end
                else if (s_axis_tdata == OPT_END)
                begin
                    emit   = 1'b1;
                    reason = STOP_END_CODE;
                end
                else if (s_axis_tdata != OPT_PAD)
                begin
                    code_next  = s_axis_tdata;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left_next   = s_axis_tdata;
                vidx_next   = '0;
                vshift_next = '0;
                if (s_axis_tdata == 8'd0)
                    finish = 1'b1;
                else
                    phase_next = PH_VAL;
            end
            PH_VAL:
            begin
                if (vidx_reg < VALUE_BYTES)
                begin
                    vshift_next = {vshift_reg[23:0], s_axis_tdata};
                    vidx_next   = vidx_reg + 3'd1;
                end
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                    finish = 1'b1;
            end
            PH_STOP:
            begin
                // hold everything: bytes after a stop are dropped
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            n = (vidx_next > VALUE_BYTES) ? VALUE_BYTES : vidx_next;
            unique case (n)
                3'd1:
                begin
                    word = {vshift_next[7:0], 24'd0};
                    lead = vshift_next[7:0];
                end
                3'd2:
                begin
                    word = {vshift_next[15:0], 16'd0};
                    lead = vshift_next[15:8];
                end
                3'd3:
                begin
                    word = {vshift_next[23:0], 8'd0};
                    lead = vshift_next[23:16];
                end
                3'd4:
                begin
                    word = vshift_next;
                    lead = vshift_next[31:24];
                end
                default:
                begin
                    word = '0;
                    lead = '0;
                end
            endcase

            unique case (code_next)
                OPT_SUBNET:
                begin
                    subnet_next              = word;
                    seen_next[FOUND_SUBNET]  = 1'b1;
                end
                OPT_GATEWAY:
                begin
                    router_next              = word;
                    seen_next[FOUND_ROUTER]  = 1'b1;
                end
                OPT_DNS:
                begin
                    dns_next                 = word;
                    seen_next[FOUND_DNS]     = 1'b1;
                end
                OPT_LEASE:
                begin
                    lease_next               = word;
                    seen_next[FOUND_LEASE]   = 1'b1;
                end
                OPT_MSG_TYPE:
                begin
                    type_next                = lead;
                    seen_next[FOUND_TYPE]    = 1'b1;
                end
                default:
                begin
                end
            endcase
            phase_next = PH_CODE;
        end

        // Advance the position for every examined byte; a stop at the code
        // boundary does not count the byte it stopped on.
        if (!emit && cur_phase != PH_STOP)
        begin
            if (cur_pos != POS_MAX)
                position_next = cur_pos + 10'd1;
            if (s_axis_tlast)
            begin
                emit   = 1'b1;
                reason = (phase_next == PH_CODE) ? STOP_PKT_END : STOP_TRUNCATED;
            end
        end

        if (emit)
            phase_next = PH_STOP;
    end

    // Summary word built from the post-update capture registers
    always_comb
    begin : result_build
        result               = '0;
        result.net_mask      = subnet_next;
        result.router        = router_next;
        result.dns_server    = dns_next;
        result.lease_seconds = lease_next;
        result.message_type  = type_next;
        result.found_mask    = seen_next;
        result.stop_reason   = reason;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CODE;
            code_reg     <= '0;
            left_reg     <= '0;
            vidx_reg     <= '0;
            vshift_reg   <= '0;
            position_reg <= '0;
            subnet_reg   <= '0;
            router_reg   <= '0;
            dns_reg      <= '0;
            lease_reg    <= '0;
            type_reg     <= '0;
            seen_reg     <= '0;
        end
        else if (s_accept)
        begin
            phase_reg    <= phase_next;
            code_reg     <= code_next;
            left_reg     <= left_next;
            vidx_reg     <= vidx_next;
            vshift_reg   <= vshift_next;
            position_reg <= position_next;
            subnet_reg   <= subnet_next;
            router_reg   <= router_next;
            dns_reg      <= dns_next;
            lease_reg    <= lease_next;
            type_reg     <= type_next;
            seen_reg     <= seen_next;
        end
    end

    // Output stage control: the skid entry fills only when the result register
    // is occupied and not being drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= s_accept && emit;
        end
        else if (s_accept && emit)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (s_accept && emit)
                out_reg <= result;
        end
        else if (s_accept && emit)
        begin
            if (out_valid_reg)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while result register empty");

    a_emit_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && emit) |=> (phase_reg == PH_STOP))
        else $error("parser did not stop after giving a summary");

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_axis_tuser && phase_reg == PH_STOP)
            |=> (phase_reg == PH_STOP) && $stable(position_reg) && $stable(seen_reg))
        else $error("state changed after stop");

    a_summary_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && emit) |=> m_axis_tvalid)
        else $error("summary lost in output stage");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

// Option-area bytes go in one transaction at a time. A model of the parse
// state, kept alongside the stream, predicts each summary, and a checker
// compares each summary that comes out with the oldest prediction.
module tb;
    import dop_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Option code outside the captured set, used to exercise the skip path
    localparam logic [7:0] OPT_UNUSED  = 8'd200;
    // Cycles the receiver holds tready low in the back-pressure test
    localparam int         HOLD_CYCLES = 300;
    // Cycles with no transaction on either side before the run is abandoned
    localparam int         QUIET_LIMIT = 4000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [9:0]          cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;   // [7:0] data_byte
    logic                s_axis_tuser  = 1'b0; // [0] first
    logic                s_axis_tlast  = 1'b0; // last
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [31:0] net_mask, [63:32] router, [95:64] dns_server,
    // [127:96] lease_seconds, [135:128] message_type, [140:136] found_mask,
    // [142:141] stop_reason, [143] zero
    logic [RESULT_W-1:0] m_axis_tdata;

    dhcp_option_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Parse-state model
    // ------------------------------------------------------------------
    phase_t      ph         = PH_CODE;
    logic [7:0]  cur_code   = '0;
    logic [7:0]  left       = '0;  // value bytes still to come
    logic [2:0]  vidx       = '0;  // value bytes captured so far, up to four
    logic [31:0] vshift     = '0;
    logic [9:0]  pos        = '0;
    logic [9:0]  limit_now  = LIMIT_RESET;
    result_t     held       = '0;  // captured values and found mask
    result_t     summary_q[$];     // predicted summaries, oldest first
    int          parsed_count = 0; // bytes that the parser actually walked

    int fail_count  = 0;
    int idle_pct    = 0;           // chance in a hundred that the sender idles
    int stall_pct   = 0;           // chance in a hundred that the receiver stalls
    int hold_asked  = 0;           // written by the tests only
    int hold_taken  = 0;           // written by the receiver only
    int hold_left   = 0;
    int quiet_cycles = 0;

    function automatic void clear_area();
        ph       = PH_CODE;
        cur_code = '0;
        left     = '0;
        vidx     = '0;
        vshift   = '0;
        pos      = '0;
        held     = '0;
    endfunction

    // Close the current option: left-align the captured bytes and store them
    // if the code is one of the five of interest.
    function automatic void close_option();
        int          n;
        logic [31:0] word;
        logic [7:0]  lead;
        n    = vidx;
        word = '0;
        lead = '0;
        if (n != 0)
        begin
            word = vshift << (8 * (4 - n));
            lead = 8'(vshift >> (8 * (n - 1)));
        end
        case (cur_code)
            OPT_SUBNET:
            begin
                held.net_mask = word;
                held.found_mask[FOUND_SUBNET] = 1'b1;
            end
            OPT_GATEWAY:
            begin
                held.router = word;
                held.found_mask[FOUND_ROUTER] = 1'b1;
            end
            OPT_DNS:
            begin
                held.dns_server = word;
                held.found_mask[FOUND_DNS] = 1'b1;
            end
            OPT_LEASE:
            begin
                held.lease_seconds = word;
                held.found_mask[FOUND_LEASE] = 1'b1;
            end
            OPT_MSG_TYPE:
            begin
                held.message_type = lead;
                held.found_mask[FOUND_TYPE] = 1'b1;
            end
            default: ;
        endcase
        ph = PH_CODE;
    endfunction

    function automatic void publish(input logic [1:0] why);
        result_t r;
        r             = held;
        r.pad         = 1'b0;
        r.stop_reason = why;
        summary_q.push_back(r);
        ph = PH_STOP;
    endfunction

    // Advance the model by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic is_first,
                                       input logic is_last);
        if (is_first)
            clear_area();
        if (ph == PH_STOP)
            return;
        parsed_count++;
        case (ph)
            PH_CODE:
            begin
                // The limit is checked before the code byte is looked at
                if (pos >= limit_now)
                begin
                    publish(STOP_LIMIT);
                    return;
                end
                if (b == OPT_END)
                begin
                    publish(STOP_END_CODE);
                    return;
                end
                if (b != OPT_PAD)
                begin
                    cur_code = b;
                    ph       = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left   = b;
                vidx   = '0;
                vshift = '0;
                if (b == 8'd0)
                    close_option();
                else
                    ph = PH_VAL;
            end
            default:
            begin
                if (vidx < VALUE_BYTES)
                begin
                    vshift = {vshift[23:0], b};
                    vidx   = vidx + 3'd1;
                end
                left = left - 8'd1;
                if (left == 8'd0)
                    close_option();
            end
        endcase
        if (pos != POS_MAX)
            pos = pos + 10'd1;
        if (is_last)
            publish(ph == PH_CODE ? STOP_PKT_END : STOP_TRUNCATED);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_taken    <= hold_asked;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void compare_field(input string fname, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", fname, want, seen);
            fail_count++;
        end
    endfunction

    // Check each summary transaction against the oldest prediction
    always @(posedge clk)
    begin : check_summary
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (summary_q.size() == 0)
            begin
                $error("summary with nothing predicted: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = summary_q.pop_front();
                compare_field("net_mask", want.net_mask, got.net_mask);
                compare_field("router", want.router, got.router);
                compare_field("dns_server", want.dns_server, got.dns_server);
                compare_field("lease_seconds", want.lease_seconds, got.lease_seconds);
                compare_field("message_type", 32'(want.message_type),
                              32'(got.message_type));
                compare_field("found_mask", 32'(want.found_mask), 32'(got.found_mask));
                compare_field("stop_reason", 32'(want.stop_reason),
                              32'(got.stop_reason));
                compare_field("pad", 32'(want.pad), 32'(got.pad));
            end
        end
    end

    // Abandon the run if neither side moves a transaction for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender and shared helpers
    // ------------------------------------------------------------------

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic is_first,
                             input logic is_last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= is_first;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b, is_first, is_last);
    endtask

    // Send a run of bytes, first flag on the opening byte, last on the final
    task automatic send_area(input byte_q_t seq, input bit with_last);
        foreach (seq[i])
            send_byte(seq[i], i == 0, with_last && (i == seq.size() - 1));
    endtask

    // Drop valid, wait for every predicted summary, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (summary_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [9:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        limit_now = value;
        cfg_we    <= 1'b0;
    endtask

    // One random options area: mostly well-formed options with random
    // content, sometimes cut short, sometimes left open, sometimes noise.
    task automatic random_area();
        byte_q_t    seq;
        logic [7:0] code;
        int         k;
        int         len;
        int         ending;
        int         keep;
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(7) == 0);
            return;
        end
        repeat ($urandom_range(0, 6))
        begin
            k = $urandom_range(19);
            if (k < 2)
                code = OPT_PAD;
            else if (k < 4)
                code = 8'($urandom_range(1, 254));
            else
                case (k % 5)
                    0:       code = OPT_SUBNET;
                    1:       code = OPT_GATEWAY;
                    2:       code = OPT_DNS;
                    3:       code = OPT_LEASE;
                    default: code = OPT_MSG_TYPE;
                endcase
            seq.push_back(code);
            if (code != OPT_PAD)
            begin
                if ($urandom_range(49) == 0)
                    len = $urandom_range(0, 255);
                else if ($urandom_range(3) == 0)
                    len = $urandom_range(0, 9);
                else
                    len = (code == OPT_MSG_TYPE) ? 1 : 4;
                seq.push_back(8'(len));
                repeat (len)
                    seq.push_back(8'($urandom));
            end
        end
        ending = $urandom_range(99);
        if (ending < 70)
        begin
            // End code, possibly followed by bytes the parser must drop
            seq.push_back(OPT_END);
            repeat ($urandom_range(0, 3))
                seq.push_back(8'($urandom));
        end
        else if (ending < 85 && seq.size() > 1)
        begin
            // Cut short: may stop mid-option or on a code boundary
            keep = $urandom_range(1, seq.size() - 1);
            while (seq.size() > keep)
                void'(seq.pop_back());
        end
        if (seq.size() == 0)
            seq.push_back(OPT_END);
        // Occasionally leave the area open so the next first byte restarts it
        send_area(seq, ending < 95);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All five captured options, a longer DNS list, a pad, an unknown code,
    // and an end code that also carries last
    task automatic test_capture_all();
        send_area('{OPT_SUBNET, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                    OPT_GATEWAY, 8'd4, 8'hC0, 8'hA8, 8'h01, 8'h01,
                    OPT_DNS, 8'd8, 8'h08, 8'h08, 8'h08, 8'h08,
                    8'h08, 8'h08, 8'h04, 8'h04,
                    OPT_LEASE, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    OPT_MSG_TYPE, 8'd1, 8'd5, OPT_PAD,
                    OPT_UNUSED, 8'd2, 8'h12, 8'h34, OPT_END}, 1'b1);
        settle();
    endtask

    // Short values, zero lengths, repeats overwriting, last on a boundary
    task automatic test_short_and_repeated();
        send_area('{OPT_SUBNET, 8'd2, 8'hAA, 8'hBB,
                    OPT_GATEWAY, 8'd0,
                    OPT_MSG_TYPE, 8'd0,
                    OPT_DNS, 8'd4, 8'h01, 8'h01, 8'h01, 8'h01,
                    OPT_DNS, 8'd4, 8'h09, 8'h09, 8'h09, 8'h09,
                    OPT_LEASE, 8'd3, 8'h01, 8'h02, 8'h03,
                    OPT_MSG_TYPE, 8'd3, 8'h06, 8'h07, 8'h08}, 1'b1);
        settle();
    endtask

    // Cut inside a value, cut after a code byte, and last after pads only
    task automatic test_truncation();
        send_area('{OPT_SUBNET, 8'd4, 8'hAA, 8'hBB}, 1'b1);
        send_area('{OPT_MSG_TYPE, 8'd1, 8'd5, OPT_GATEWAY}, 1'b1);
        send_area('{OPT_PAD, OPT_PAD}, 1'b1);
        send_byte(OPT_PAD, 1'b1, 1'b1);
        settle();
    endtask

    // Bytes after a stop are dropped until the next first; first mid-area
    // discards everything captured so far
    task automatic test_after_stop();
        send_area('{OPT_MSG_TYPE, 8'd1, 8'd2, OPT_END, OPT_SUBNET, 8'd4,
                    8'h01, 8'h02, 8'h03, 8'h04, 8'h07}, 1'b1);
        send_byte(OPT_SUBNET, 1'b0, 1'b1);
        send_area('{OPT_SUBNET, 8'd4, 8'h0A, 8'h0B}, 1'b0);
        send_area('{OPT_GATEWAY, 8'd4, 8'hC0, 8'hA8, 8'h00, 8'h01, OPT_END}, 1'b1);
        send_byte(OPT_END, 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_limit_edges();
        // Limit and end code on the same byte: the limit wins
        write_limit(10'd3);
        send_area('{OPT_MSG_TYPE, 8'd1, 8'd2, OPT_END}, 1'b1);
        // An option begun before the limit is read to its end
        write_limit(10'd1);
        send_area('{OPT_LEASE, 8'd4, 8'h00, 8'h01, 8'h51, 8'h80,
                    OPT_SUBNET, 8'd4}, 1'b1);
        // Last on the byte at the limit still reports the limit
        write_limit(10'd2);
        send_area('{OPT_PAD, OPT_PAD, OPT_END}, 1'b1);
        // Limit of zero stops on the very first byte
        write_limit(10'd0);
        send_byte(OPT_SUBNET, 1'b1, 1'b1);
        send_area('{OPT_END, OPT_GATEWAY}, 1'b1);
        write_limit(LIMIT_RESET);
    endtask

    // Drive the byte position past its ceiling inside one long option
    task automatic test_position_saturation();
        byte_q_t seq;
        write_limit(POS_MAX);
        repeat (1020)
            seq.push_back(OPT_PAD);
        seq.push_back(OPT_UNUSED);
        seq.push_back(8'd255);
        repeat (255)
            seq.push_back(8'($urandom));
        seq.push_back(OPT_MSG_TYPE);
        send_area(seq, 1'b1);
        write_limit(LIMIT_RESET);
    endtask

    // Hold the receiver off while short areas keep coming, so both output
    // entries fill and the block stalls its input
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        @(negedge clk);
        hold_asked = hold_asked + 1;
        @(posedge clk);
        repeat (30)
            send_area('{OPT_MSG_TYPE, 8'd1, 8'($urandom), OPT_END}, 1'b1);
        settle();
    endtask

    task automatic test_random(input int sender_idle, input int receiver_stall,
                               input logic [9:0] lim, input int items);
        int target;
        write_limit(lim);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = parsed_count + items;
        while (parsed_count < target)
            random_area();
        // Close whatever area is left open before the next limit write
        send_byte(OPT_END, 1'b1, 1'b1);
        settle();
    endtask

    initial
    begin
        clear_area();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct  = 20;
        stall_pct = 20;
        test_capture_all();
        test_short_and_repeated();
        test_truncation();
        test_after_stop();
        test_limit_edges();
        test_position_saturation();
        test_backpressure();

        test_random(0, 0, LIMIT_RESET, 300);
        test_random(83, 0, 10'($urandom_range(1, 48)), 300);
        test_random(0, 83, POS_MAX, 300);
        test_random(37, 37, 10'($urandom_range(1, 1023)), 300);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && summary_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
